/* sv/amr_box_refine_coarsen_unit_assert.svh */
// assertion macros for the box refine / coarsen unit checker
// depends on nothing; included by the checker file
`ifndef AMR_BOX_REFINE_COARSEN_UNIT_ASSERT_SVH
`define AMR_BOX_REFINE_COARSEN_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ABRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ABRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define ABRC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/abrc_pkg.sv */
// shared constants, types and helpers of the box refine / coarsen unit
// depends on nothing
package abrc_pkg;

    localparam int COORD_W    = 24;
    localparam int RATIO_W    = 9;
    localparam int WIDE_W     = COORD_W + RATIO_W + 2;
    localparam int NUM_LANES  = 6;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (COORD_W + DIV_STEP - 1) / DIV_STEP;
    localparam int STG_W      = $clog2(DIV_STAGES);

    localparam logic [2:0] MODE_REFINE      = 3'd0;
    localparam logic [2:0] MODE_NODE_REFINE = 3'd1;
    localparam logic [2:0] MODE_COARSEN     = 3'd2;
    localparam logic [2:0] MODE_COARSEN_OUT = 3'd3;
    localparam logic [2:0] MODE_GROW_LO     = 3'd4;
    localparam logic [2:0] MODE_GROW_HI     = 3'd5;
    localparam logic [2:0] MODE_SHIFT       = 3'd6;

    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(2);

    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // one coordinate in flight
    typedef struct packed {
        logic                 use_div;  // result comes from the divider
        logic                 neg;      // dividend was negative
        logic                 up;       // round toward +inf (ceiling)
        logic                 dec;      // subtract one after the product
        logic [COORD_W-1:0]   num;      // dividend bits, quotient shifts in
        logic [RATIO_W-1:0]   rem;      // partial remainder
        logic [WIDE_W-1:0]    wide;     // exact non-divide result
    } t_lane;

    typedef struct packed {
        t_lane [NUM_LANES-1:0] lane;  // lo x,y,z then hi x,y,z
    } t_item;

    typedef struct packed {
        logic [NUM_LANES-1:0][COORD_W-1:0] coord;
        logic                              ovf;
    } t_result;

    // a ratio of zero behaves as one
    function automatic logic [RATIO_W-1:0] eff_ratio(input logic [RATIO_W-1:0] r);
        eff_ratio = (r == '0) ? RATIO_W'(1) : r;
    endfunction

endpackage

/* sv/amr_box_refine_coarsen_unit.sv */
// box refine / coarsen unit top level: handshake, pipeline registers, ratio register
// depends on abrc_pkg, abrc_prep, abrc_div_step, abrc_finish
//
// usage
//   input channel: i_valid / o_stall with mode, box corners, axis and amount;
//   a transaction is taken at a clock edge with i_valid high and o_stall low
//   output channel: o_valid / i_stall with the new box and the overflow flag;
//   a transaction leaves at an edge with o_valid high and i_stall low
//   ref_ratio: written by i_ref_ratio_we / i_ref_ratio; the user must write it only while
//   the unit is idle, the block itself does not enforce this
//   structure: 1 setup stage, 6 divider stages of 4 quotient bits each, 1
//   rounding/clamp stage into the output reg that drives o_valid
//   throughput: one box per cycle while o_stall is low; the six restoring divider
//   lanes (9-bit divisor) are pipelined so every stage takes a new box each cycle unless held
//   stall: each stage advances when its successor is free, so bubbles close up
//   and only a full pipeline raises o_stall; nothing is lost or repeated
//   reset (synchronous, active low): all stage valids clear, ratio returns to 2
module amr_box_refine_coarsen_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [2:0]                      i_mode,
    input  logic [abrc_pkg::COORD_W-1:0]    i_lo_x,
    input  logic [abrc_pkg::COORD_W-1:0]    i_lo_y,
    input  logic [abrc_pkg::COORD_W-1:0]    i_lo_z,
    input  logic [abrc_pkg::COORD_W-1:0]    i_hi_x,
    input  logic [abrc_pkg::COORD_W-1:0]    i_hi_y,
    input  logic [abrc_pkg::COORD_W-1:0]    i_hi_z,
    input  logic [1:0]                      i_axis,
    input  logic [abrc_pkg::COORD_W-1:0]    i_amount,
    input  logic                            i_ref_ratio_we,
    input  logic [abrc_pkg::RATIO_W-1:0]    i_ref_ratio,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [abrc_pkg::COORD_W-1:0]    o_new_lo_x,
    output logic [abrc_pkg::COORD_W-1:0]    o_new_lo_y,
    output logic [abrc_pkg::COORD_W-1:0]    o_new_lo_z,
    output logic [abrc_pkg::COORD_W-1:0]    o_new_hi_x,
    output logic [abrc_pkg::COORD_W-1:0]    o_new_hi_y,
    output logic [abrc_pkg::COORD_W-1:0]    o_new_hi_z,
    output logic                            o_overflow
);

    localparam int NS = abrc_pkg::DIV_STAGES;

    // ratio register
    logic [abrc_pkg::RATIO_W-1:0] r_ratio;

    // stage 0 is the setup register, stages 1..NS hold divider progress
    abrc_pkg::t_item    r_item [NS+1];
    logic [NS:0]        r_v;
    abrc_pkg::t_result  r_out;
    logic               r_out_v;

    abrc_pkg::t_item    n_item [NS+1];
    abrc_pkg::t_result  n_out;
    logic [NS:0]        w_adv;
    logic               w_adv_out;

    logic [abrc_pkg::NUM_LANES-1:0][abrc_pkg::COORD_W-1:0] w_coord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= abrc_pkg::RATIO_RESET;
        end else if (i_ref_ratio_we) begin
            r_ratio <= i_ref_ratio;
        end
    end

    // a stage moves when it is empty or its successor moves
    always_comb begin
        w_adv_out = !r_out_v || !i_stall;
        w_adv[NS] = !r_v[NS] || w_adv_out;
        for (int k = NS - 1; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    assign o_stall = !w_adv[0];

    assign w_coord = {i_hi_z, i_hi_y, i_hi_x, i_lo_z, i_lo_y, i_lo_x};

    // setup: products, sums, dividend magnitudes
    abrc_prep u_prep (
        .i_mode   (i_mode),
        .i_coord  (w_coord),
        .i_axis   (i_axis),
        .i_amount (i_amount),
        .i_ratio  (r_ratio),
        .o_item   (n_item[0])
    );

    // divider stages
    for (genvar k = 1; k <= NS; k++) begin : g_div
        abrc_div_step u_step (
            .i_item  (r_item[k-1]),
            .i_stage (abrc_pkg::STG_W'(k - 1)),
            .i_ratio (r_ratio),
            .o_item  (n_item[k])
        );
    end

    // rounding and clamp into the output register
    abrc_finish u_finish (
        .i_item (r_item[NS]),
        .o_res  (n_out)
    );

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (w_adv[0]) r_v[0] <= i_valid;
            for (int k = 1; k <= NS; k++) begin
                if (w_adv[k]) r_v[k] <= r_v[k-1];
            end
            if (w_adv_out) r_out_v <= r_v[NS];
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= NS; k++) begin
            if (w_adv[k]) r_item[k] <= n_item[k];
        end
        if (w_adv_out) r_out <= n_out;
    end

    assign o_valid    = r_out_v;
    assign o_new_lo_x = r_out.coord[0];
    assign o_new_lo_y = r_out.coord[1];
    assign o_new_lo_z = r_out.coord[2];
    assign o_new_hi_x = r_out.coord[3];
    assign o_new_hi_y = r_out.coord[4];
    assign o_new_hi_z = r_out.coord[5];
    assign o_overflow = r_out.ovf;

endmodule

/* sv/abrc_prep.sv */
// first stage logic: mode decode, products, grow/shift sums, divider setup
// depends on abrc_pkg
module abrc_prep (
    input  logic [2:0]                              i_mode,
    input  logic [abrc_pkg::NUM_LANES-1:0][abrc_pkg::COORD_W-1:0] i_coord,
    input  logic [1:0]                              i_axis,
    input  logic [abrc_pkg::COORD_W-1:0]            i_amount,
    input  logic [abrc_pkg::RATIO_W-1:0]            i_ratio,
    output abrc_pkg::t_item                         o_item
);

    logic signed [abrc_pkg::WIDE_W-1:0]  w_src   [abrc_pkg::NUM_LANES];
    logic signed [abrc_pkg::WIDE_W-1:0]  w_prod  [abrc_pkg::NUM_LANES];
    logic signed [abrc_pkg::COORD_W:0]   w_mop   [abrc_pkg::NUM_LANES];
    logic signed [abrc_pkg::WIDE_W-1:0]  w_amt;
    logic signed [abrc_pkg::RATIO_W:0]   w_rs;

    always_comb begin
        w_amt = abrc_pkg::WIDE_W'($signed(i_amount));
        w_rs  = $signed({1'b0, abrc_pkg::eff_ratio(i_ratio)});
        for (int c = 0; c < abrc_pkg::NUM_LANES; c++) begin
            w_src[c] = abrc_pkg::WIDE_W'($signed(i_coord[c]));
            // cell refine of the upper corner multiplies hi+1
            if (i_mode == abrc_pkg::MODE_REFINE && c >= 3) begin
                w_mop[c] = $signed({i_coord[c][abrc_pkg::COORD_W-1], i_coord[c]})
                         + (abrc_pkg::COORD_W+1)'(1);
            end else begin
                w_mop[c] = $signed({i_coord[c][abrc_pkg::COORD_W-1], i_coord[c]});
            end
            w_prod[c] = w_mop[c] * w_rs;
        end
    end

    always_comb begin
        logic hit;
        logic is_hi;
        for (int c = 0; c < abrc_pkg::NUM_LANES; c++) begin
            is_hi = (c >= 3);
            hit   = (i_axis == 2'(c % 3));
            o_item.lane[c].neg     = i_coord[c][abrc_pkg::COORD_W-1];
            o_item.lane[c].num     = i_coord[c][abrc_pkg::COORD_W-1] ? -i_coord[c]
                                                                     : i_coord[c];
            o_item.lane[c].rem     = '0;
            o_item.lane[c].use_div = 1'b0;
            o_item.lane[c].up      = 1'b0;
            o_item.lane[c].dec     = 1'b0;
            o_item.lane[c].wide    = w_src[c];
            case (i_mode)
                abrc_pkg::MODE_REFINE: begin
                    o_item.lane[c].wide = w_prod[c];
                    o_item.lane[c].dec  = is_hi;
                end
                abrc_pkg::MODE_NODE_REFINE: begin
                    o_item.lane[c].wide = w_prod[c];
                end
                abrc_pkg::MODE_COARSEN: begin
                    o_item.lane[c].use_div = 1'b1;
                end
                abrc_pkg::MODE_COARSEN_OUT: begin
                    o_item.lane[c].use_div = 1'b1;
                    o_item.lane[c].up      = is_hi;
                end
                abrc_pkg::MODE_GROW_LO: begin
                    if (!is_hi && hit) o_item.lane[c].wide = w_src[c] - w_amt;
                end
                abrc_pkg::MODE_GROW_HI: begin
                    if (is_hi && hit) o_item.lane[c].wide = w_src[c] + w_amt;
                end
                abrc_pkg::MODE_SHIFT: begin
                    if (hit) o_item.lane[c].wide = w_src[c] + w_amt;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* sv/abrc_div_step.sv */
// one divider stage: four restoring quotient bits for all six lanes
// depends on abrc_pkg
module abrc_div_step (
    input  abrc_pkg::t_item                 i_item,
    input  logic [abrc_pkg::STG_W-1:0]      i_stage,
    input  logic [abrc_pkg::RATIO_W-1:0]    i_ratio,
    output abrc_pkg::t_item                 o_item
);

    logic [abrc_pkg::RATIO_W-1:0] w_d;

    always_comb begin
        logic [abrc_pkg::RATIO_W:0]   rem2;
        logic [abrc_pkg::COORD_W-1:0] num;
        logic [abrc_pkg::RATIO_W-1:0] rem;
        w_d    = abrc_pkg::eff_ratio(i_ratio);
        o_item = i_item;
        for (int c = 0; c < abrc_pkg::NUM_LANES; c++) begin
            num = i_item.lane[c].num;
            rem = i_item.lane[c].rem;
            for (int j = 0; j < abrc_pkg::DIV_STEP; j++) begin
                // last stage may hold fewer real bits
                if (int'(i_stage) * abrc_pkg::DIV_STEP + j < abrc_pkg::COORD_W) begin
                    rem2 = {rem, num[abrc_pkg::COORD_W-1]};
                    num  = {num[abrc_pkg::COORD_W-2:0], 1'b0};
                    if (rem2 >= {1'b0, w_d}) begin
                        rem    = abrc_pkg::RATIO_W'(rem2 - {1'b0, w_d});
                        num[0] = 1'b1;
                    end else begin
                        rem = abrc_pkg::RATIO_W'(rem2);
                    end
                end
            end
            o_item.lane[c].num = num;
            o_item.lane[c].rem = rem;
        end
    end

endmodule

/* sv/abrc_finish.sv */
// last stage logic: quotient rounding, final offset, clamp and overflow
// depends on abrc_pkg
module abrc_finish (
    input  abrc_pkg::t_item     i_item,
    output abrc_pkg::t_result   o_res
);

    localparam logic signed [abrc_pkg::WIDE_W-1:0] LIM_HI =
        abrc_pkg::WIDE_W'($signed({1'b0, abrc_pkg::COORD_MAX}));
    localparam logic signed [abrc_pkg::WIDE_W-1:0] LIM_LO =
        abrc_pkg::WIDE_W'($signed(abrc_pkg::COORD_MIN));

    always_comb begin
        logic                               nz;
        logic                               inc;
        logic [abrc_pkg::COORD_W:0]         mag;
        logic signed [abrc_pkg::WIDE_W-1:0] val;
        o_res.ovf = 1'b0;
        for (int c = 0; c < abrc_pkg::NUM_LANES; c++) begin
            nz  = (i_item.lane[c].rem != '0);
            inc = nz & (i_item.lane[c].up ^ i_item.lane[c].neg);
            mag = {1'b0, i_item.lane[c].num} + (abrc_pkg::COORD_W+1)'(inc);
            if (i_item.lane[c].use_div) begin
                val = i_item.lane[c].neg ? -abrc_pkg::WIDE_W'(mag)
                                         :  abrc_pkg::WIDE_W'(mag);
            end else begin
                val = $signed(i_item.lane[c].wide)
                    - abrc_pkg::WIDE_W'(i_item.lane[c].dec);
            end
            if (val > LIM_HI) begin
                o_res.coord[c] = abrc_pkg::COORD_MAX;
                o_res.ovf      = 1'b1;
            end else if (val < LIM_LO) begin
                o_res.coord[c] = abrc_pkg::COORD_MIN;
                o_res.ovf      = 1'b1;
            end else begin
                o_res.coord[c] = val[abrc_pkg::COORD_W-1:0];
            end
        end
    end

endmodule

/* sv/abrc_checker.sv */
// port-level checker for the box refine / coarsen unit, with its bind
// depends on abrc_pkg and amr_box_refine_coarsen_unit_assert.svh
`include "amr_box_refine_coarsen_unit_assert.svh"

module abrc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            o_stall,
    input  logic [2:0]                      i_mode,
    input  logic [abrc_pkg::COORD_W-1:0]    i_lo_x,
    input  logic [abrc_pkg::COORD_W-1:0]    i_lo_y,
    input  logic [abrc_pkg::COORD_W-1:0]    i_lo_z,
    input  logic [abrc_pkg::COORD_W-1:0]    i_hi_x,
    input  logic [abrc_pkg::COORD_W-1:0]    i_hi_y,
    input  logic [abrc_pkg::COORD_W-1:0]    i_hi_z,
    input  logic [1:0]                      i_axis,
    input  logic [abrc_pkg::COORD_W-1:0]    i_amount,
    input  logic                            i_ref_ratio_we,
    input  logic [abrc_pkg::RATIO_W-1:0]    i_ref_ratio,
    input  logic                            o_valid,
    input  logic                            i_stall,
    input  logic [abrc_pkg::COORD_W-1:0]    o_new_lo_x,
    input  logic [abrc_pkg::COORD_W-1:0]    o_new_lo_y,
    input  logic [abrc_pkg::COORD_W-1:0]    o_new_lo_z,
    input  logic [abrc_pkg::COORD_W-1:0]    o_new_hi_x,
    input  logic [abrc_pkg::COORD_W-1:0]    o_new_hi_y,
    input  logic [abrc_pkg::COORD_W-1:0]    o_new_hi_z,
    input  logic                            o_overflow
);

    logic w_any_lim;

    assign w_any_lim =
        o_new_lo_x == abrc_pkg::COORD_MAX || o_new_lo_x == abrc_pkg::COORD_MIN ||
        o_new_lo_y == abrc_pkg::COORD_MAX || o_new_lo_y == abrc_pkg::COORD_MIN ||
        o_new_lo_z == abrc_pkg::COORD_MAX || o_new_lo_z == abrc_pkg::COORD_MIN ||
        o_new_hi_x == abrc_pkg::COORD_MAX || o_new_hi_x == abrc_pkg::COORD_MIN ||
        o_new_hi_y == abrc_pkg::COORD_MAX || o_new_hi_y == abrc_pkg::COORD_MIN ||
        o_new_hi_z == abrc_pkg::COORD_MAX || o_new_hi_z == abrc_pkg::COORD_MIN;

    // a stalled result stays offered
    `ABRC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid,
        "result dropped while stalled")
    // an empty output register never backs up the input
    `ABRC_ASSERT_IMP(a_no_false_stall, i_clk, i_rst_n, !o_valid, !o_stall,
        "input stalled with empty pipeline")
    // overflow means some coordinate sits at a range limit
    `ABRC_ASSERT_IMP(a_ovf_sat, i_clk, i_rst_n, o_valid && o_overflow, w_any_lim,
        "overflow without saturated coordinate")
    // reset empties the pipeline
    `ABRC_ASSERT_NXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_valid,
        "result present after reset")

endmodule

bind amr_box_refine_coarsen_unit abrc_checker u_abrc_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for amr_box_refine_coarsen_unit: directed and random boxes
// depends on abrc_pkg and the unit rtl; predicts each box transform and checks it in order
module testbench;

    localparam int COORD_W = abrc_pkg::COORD_W;
    localparam int RATIO_W = abrc_pkg::RATIO_W;
    localparam logic [RATIO_W-1:0] RATIO_RESET = abrc_pkg::RATIO_RESET;
    localparam logic [COORD_W-1:0] COORD_MAX = abrc_pkg::COORD_MAX;
    localparam logic [COORD_W-1:0] COORD_MIN = abrc_pkg::COORD_MIN;
    localparam logic [2:0] MODE_REFINE      = abrc_pkg::MODE_REFINE;
    localparam logic [2:0] MODE_NODE_REFINE = abrc_pkg::MODE_NODE_REFINE;
    localparam logic [2:0] MODE_COARSEN     = abrc_pkg::MODE_COARSEN;
    localparam logic [2:0] MODE_COARSEN_OUT = abrc_pkg::MODE_COARSEN_OUT;
    localparam logic [2:0] MODE_GROW_LO     = abrc_pkg::MODE_GROW_LO;
    localparam logic [2:0] MODE_GROW_HI     = abrc_pkg::MODE_GROW_HI;
    localparam logic [2:0] MODE_SHIFT       = abrc_pkg::MODE_SHIFT;
    localparam logic [2:0] MODE_UNUSED      = 3'd7;   // passes the box unchanged

    localparam int LATENCY = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam longint CMAX = (64'sd1 <<< (COORD_W - 1)) - 1;
    localparam longint CMIN = -(64'sd1 <<< (COORD_W - 1));

    // one box transaction on the input side
    typedef struct {
        logic [2:0]         mode;
        logic [COORD_W-1:0] lo [3];
        logic [COORD_W-1:0] hi [3];
        logic [1:0]         axis;
        logic [COORD_W-1:0] amount;
    } t_box_req;

    // one expected box on the output side
    typedef struct {
        logic [COORD_W-1:0] lo [3];
        logic [COORD_W-1:0] hi [3];
        logic               ovf;
    } t_box_res;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_mode = '0;
    logic [COORD_W-1:0] i_lo_x = '0, i_lo_y = '0, i_lo_z = '0;
    logic [COORD_W-1:0] i_hi_x = '0, i_hi_y = '0, i_hi_z = '0;
    logic [1:0]         i_axis = '0;
    logic [COORD_W-1:0] i_amount = '0;
    logic               i_ref_ratio_we = 1'b0;
    logic [RATIO_W-1:0] i_ref_ratio = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [COORD_W-1:0] o_new_lo_x, o_new_lo_y, o_new_lo_z;
    logic [COORD_W-1:0] o_new_hi_x, o_new_hi_y, o_new_hi_z;
    logic               o_overflow;

    // predictor copy of the ratio register
    logic [RATIO_W-1:0] ratio_shadow = RATIO_RESET;

    t_box_res expected_boxes[$];
    int       error_count = 0;
    int       boxes_sent = 0;
    int       boxes_checked = 0;
    int       idle_cycles = 0;
    bit       quiet_mode = 1'b0;      // no idling on either side near the end
    bit       hold_receiver = 1'b0;   // request a long output hold-off
    bit       timed_out = 1'b0;

    always #6 i_clk = ~i_clk;

    amr_box_refine_coarsen_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(i_mode),
        .i_lo_x(i_lo_x), .i_lo_y(i_lo_y), .i_lo_z(i_lo_z),
        .i_hi_x(i_hi_x), .i_hi_y(i_hi_y), .i_hi_z(i_hi_z),
        .i_axis(i_axis), .i_amount(i_amount),
        .i_ref_ratio_we(i_ref_ratio_we), .i_ref_ratio(i_ref_ratio),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_new_lo_x(o_new_lo_x), .o_new_lo_y(o_new_lo_y), .o_new_lo_z(o_new_lo_z),
        .o_new_hi_x(o_new_hi_x), .o_new_hi_y(o_new_hi_y), .o_new_hi_z(o_new_hi_z),
        .o_overflow(o_overflow)
    );

    // floor and ceiling division with a positive divisor
    function automatic longint floor_div(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint ceil_div(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a > 0) q = q + 1;
        return q;
    endfunction

    // clamp to the coordinate range, flagging saturation
    function automatic logic [COORD_W-1:0] saturate(longint v, inout logic ovf);
        if (v > CMAX) begin
            ovf = 1'b1;
            v = CMAX;
        end else if (v < CMIN) begin
            ovf = 1'b1;
            v = CMIN;
        end
        return v[COORD_W-1:0];
    endfunction

    // transformed box for one request under the current ratio
    function automatic t_box_res transform_box(t_box_req q);
        t_box_res res;
        longint   r, a, b, lo, hi, amt;
        logic     ovf;
        ovf = 1'b0;
        r = (ratio_shadow == '0) ? 1 : longint'(ratio_shadow);
        amt = longint'(signed'(q.amount));
        for (int i = 0; i < 3; i++) begin
            lo = longint'(signed'(q.lo[i]));
            hi = longint'(signed'(q.hi[i]));
            a = lo;
            b = hi;
            case (q.mode)
                MODE_REFINE: begin
                    a = lo * r;
                    b = (hi + 1) * r - 1;
                end
                MODE_NODE_REFINE: begin
                    a = lo * r;
                    b = hi * r;
                end
                MODE_COARSEN: begin
                    a = floor_div(lo, r);
                    b = floor_div(hi, r);
                end
                MODE_COARSEN_OUT: begin
                    a = floor_div(lo, r);
                    b = ceil_div(hi, r);
                end
                MODE_GROW_LO: if (q.axis == i) a = lo - amt;
                MODE_GROW_HI: if (q.axis == i) b = hi + amt;
                MODE_SHIFT: if (q.axis == i) begin
                    a = lo + amt;
                    b = hi + amt;
                end
                default: ;
            endcase
            res.lo[i] = saturate(a, ovf);
            res.hi[i] = saturate(b, ovf);
        end
        res.ovf = ovf;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [COORD_W-1:0] got,
                                   logic [COORD_W-1:0] want);
        error_count++;
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    // random coordinate, biased toward edges and small values
    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return COORD_MAX - COORD_W'($urandom_range(0, 3));
            1: return COORD_MIN + COORD_W'($urandom_range(0, 3));
            2: return COORD_W'($urandom_range(0, 40)) - COORD_W'(20);
            3: return COORD_W'($urandom_range(0, 2000)) - COORD_W'(1000);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // drive one transaction and wait for its acceptance; valid stays up
    // afterwards so the next transaction can follow with no gap
    task automatic send_box(t_box_req q);
        int gap;
        if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_mode   <= q.mode;
        i_lo_x   <= q.lo[0];
        i_lo_y   <= q.lo[1];
        i_lo_z   <= q.lo[2];
        i_hi_x   <= q.hi[0];
        i_hi_y   <= q.hi[1];
        i_hi_z   <= q.hi[2];
        i_axis   <= q.axis;
        i_amount <= q.amount;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_boxes.push_back(transform_box(q));
        boxes_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_box_req make_box(logic [2:0] mode, longint lo, longint hi,
                                          logic [1:0] axis, longint amt);
        t_box_req q;
        q.mode = mode;
        for (int i = 0; i < 3; i++) begin
            q.lo[i] = COORD_W'(lo + i);
            q.hi[i] = COORD_W'(hi - i);
        end
        q.axis = axis;
        q.amount = COORD_W'(amt);
        return q;
    endfunction

    function automatic t_box_req random_box();
        t_box_req q;
        q.mode = 3'($urandom_range(0, 7));
        for (int i = 0; i < 3; i++) begin
            q.lo[i] = rand_coord();
            // mostly well-formed boxes, some inverted
            q.hi[i] = ($urandom_range(0, 4) == 0) ? rand_coord()
                      : q.lo[i] + COORD_W'($urandom_range(0, 64));
        end
        q.axis = 2'($urandom);
        q.amount = rand_coord();
        return q;
    endfunction

    // stop offering and wait for the pipeline to drain before a register write
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_boxes.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic write_ratio(logic [RATIO_W-1:0] value);
        wait_drained();
        i_ref_ratio_we <= 1'b1;
        i_ref_ratio    <= value;
        @(negedge i_clk);
        i_ref_ratio_we <= 1'b0;
        ratio_shadow = value;
    endtask

    // every mode and the special cases at the reset ratio and a few others
    task automatic test_directed();
        send_box(make_box(MODE_REFINE, 0, 0, 0, 0));          // point box on x, inverted on y and z
        send_box(make_box(MODE_REFINE, CMIN, CMAX, 0, 0));    // saturating refine
        send_box(make_box(MODE_NODE_REFINE, -5, 7, 1, 0));
        send_box(make_box(MODE_COARSEN, -7, 7, 2, 0));
        send_box(make_box(MODE_COARSEN_OUT, -1, 0, 0, 0));    // outward with hi of zero
        send_box(make_box(MODE_COARSEN_OUT, CMIN, CMAX, 0, 0));
        send_box(make_box(MODE_GROW_LO, 3, 9, 0, CMAX));
        send_box(make_box(MODE_GROW_HI, 3, 9, 1, CMAX));
        send_box(make_box(MODE_SHIFT, CMIN, CMAX, 2, CMIN));
        send_box(make_box(MODE_SHIFT, 1, 2, 3, 100));         // axis none
        send_box(make_box(MODE_UNUSED, -3, 4, 0, 5));         // unused mode
        send_box(make_box(MODE_COARSEN, 9, -9, 0, 0));        // inverted box
        write_ratio('0);                                      // ratio zero acts as one
        send_box(make_box(MODE_REFINE, -4, 4, 0, 0));
        send_box(make_box(MODE_COARSEN_OUT, -4, 5, 0, 0));
        write_ratio(9'd511);                                  // above the nominal range
        send_box(make_box(MODE_REFINE, 16000, -16000, 0, 0));
        send_box(make_box(MODE_COARSEN_OUT, CMIN, CMAX, 0, 0));
        write_ratio(9'd256);
        send_box(make_box(MODE_NODE_REFINE, 32767, -32768, 0, 0));
        send_box(make_box(MODE_COARSEN, -257, 255, 0, 0));
    endtask

    // random boxes under several ratios, including zero, one and a random ratio
    task automatic test_random(int count);
        logic [RATIO_W-1:0] ratios [6] = '{9'd1, 9'd2, 9'd3, 9'd7, 9'd256, 9'd0};
        for (int p = 0; p < 6; p++) begin
            write_ratio(ratios[p]);
            for (int n = 0; n < count / 6; n++) send_box(random_box());
        end
        write_ratio(RATIO_W'($urandom_range(1, 511)));
        for (int n = 0; n < count / 6; n++) send_box(random_box());
    endtask

    // receiver holds off while the sender keeps offering, then the sender drains
    task automatic test_backpressure();
        hold_receiver = 1'b1;
        for (int n = 0; n < 40; n++) send_box(random_box());
        wait_drained();
    endtask

    // no idling at all in the last stretch
    task automatic test_streaming();
        quiet_mode = 1'b1;
        for (int n = 0; n < 150; n++) send_box(random_box());
    endtask

    // output side: random stall bursts plus one long requested hold-off
    initial begin
        int burst;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_receiver) begin
                hold_receiver = 1'b0;
                i_stall <= 1'b1;
                repeat (60) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 18);
                i_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // result checker, in order against the oldest expectation
    always @(posedge i_clk) begin
        t_box_res want;
        logic [COORD_W-1:0] got_lo [3];
        logic [COORD_W-1:0] got_hi [3];
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_boxes.size() == 0) begin
                report_mismatch("unexpected result transaction, new_lo[0]", o_new_lo_x,
                                COORD_W'(0));
            end else begin
                want = expected_boxes.pop_front();
                got_lo = '{o_new_lo_x, o_new_lo_y, o_new_lo_z};
                got_hi = '{o_new_hi_x, o_new_hi_y, o_new_hi_z};
                for (int i = 0; i < 3; i++) begin
                    if (got_lo[i] !== want.lo[i])
                        report_mismatch($sformatf("new_lo[%0d]", i), got_lo[i], want.lo[i]);
                    if (got_hi[i] !== want.hi[i])
                        report_mismatch($sformatf("new_hi[%0d]", i), got_hi[i], want.hi[i]);
                end
                if (o_overflow !== want.ovf)
                    report_mismatch("overflow", COORD_W'(o_overflow), COORD_W'(want.ovf));
                boxes_checked++;
            end
        end
    end

    // watchdog: cycles without any accepted transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d results outstanding", expected_boxes.size());
            $display("amr_box_refine_coarsen_unit verification failed");
            $finish;
        end
    end

    initial begin
        int spin;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(870);
        test_backpressure();
        test_streaming();
        i_valid <= 1'b0;
        spin = 0;
        while (expected_boxes.size() != 0 && spin < 2000) begin
            @(negedge i_clk);
            spin++;
        end
        repeat (LATENCY + 4) @(negedge i_clk);
        if (expected_boxes.size() != 0)
            report_mismatch("results never arrived, outstanding count", COORD_W'(0),
                            COORD_W'(expected_boxes.size()));
        $display("covered %0d boxes over all modes and ratios 0,1,2,3,7,256,511 and random",
                 boxes_sent);
        $display("%0d results checked, %0d mismatches", boxes_checked, error_count);
        if (error_count == 0)
            $display("amr_box_refine_coarsen_unit verification clean");
        else
            $display("amr_box_refine_coarsen_unit verification failed");
        $finish;
    end
endmodule

/* sim.f */
+incdir+sv
sv/abrc_pkg.sv
sv/abrc_prep.sv
sv/abrc_div_step.sv
sv/abrc_finish.sv
sv/amr_box_refine_coarsen_unit.sv
sv/abrc_checker.sv
tb/sv/testbench.sv
